### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by fesrm_walk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FESRM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true out of reset
`define FESRM_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define FESRM_ASSERT(label, clk, rst, prop)
`define FESRM_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/fesrm_pkg.sv
// ----------------------------------------------------------------------------
// fesrm_pkg
// shared constants and types of the erase sector range mapper
// ----------------------------------------------------------------------------
package fesrm_pkg;

   localparam int MAX_SECTORS  = 64;
   localparam int MAX_REGIONS  = 4;
   localparam int REGION_SLOTS = 4;
   localparam int RIDX_W       = $clog2(REGION_SLOTS);
   localparam int CNT_W        = $clog2(MAX_SECTORS + 1);
   localparam int SIZE_SHIFT   = 8;

   localparam logic [2:0] REG_FLASH_BASE   = 3'd0;
   localparam logic [2:0] REG_REGION_COUNT = 3'd1;
   localparam logic [2:0] REG_REGION0      = 3'd2;
   localparam logic [2:0] REG_REGION1      = 3'd3;
   localparam logic [2:0] REG_REGION2      = 3'd4;
   localparam logic [2:0] REG_REGION3      = 3'd5;

   typedef struct packed {
      logic [31:0]                   flash_base;
      logic [2:0]                    region_count;
      logic [REGION_SLOTS-1:0][31:0] region_info;
   } cfg_type;

   typedef struct packed {
      logic [31:0] sector_addr;
      logic        valid_res;
      logic        last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } walk_state_type;

endpackage

### rtl/fesrm_csr.sv
// ----------------------------------------------------------------------------
// fesrm_csr
// configuration registers with region count clamp
// ----------------------------------------------------------------------------
module fesrm_csr import fesrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   logic [31:0]                   base_ff,  base_in;
   logic [2:0]                    count_ff, count_in;
   logic [REGION_SLOTS-1:0][31:0] info_ff,  info_in;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      info_in  = info_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FLASH_BASE:   base_in    = csr_wdata;
            REG_REGION_COUNT: count_in   = csr_wdata[2:0];
            REG_REGION0:      info_in[0] = csr_wdata;
            REG_REGION1:      info_in[1] = csr_wdata;
            REG_REGION2:      info_in[2] = csr_wdata;
            REG_REGION3:      info_in[3] = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
         info_ff  <= '0;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
         info_ff  <= info_in;
      end
   end

   assign cfg.flash_base   = base_ff;
   assign cfg.region_count = (count_ff > 3'(MAX_REGIONS)) ? 3'(MAX_REGIONS) : count_ff;
   assign cfg.region_info  = info_ff;

endmodule

### rtl/fesrm_blk_unit.sv
// ----------------------------------------------------------------------------
// fesrm_blk_unit
// block unit: next block address and range hit test
// ----------------------------------------------------------------------------
module fesrm_blk_unit import fesrm_pkg::*; (
   input  logic [31:0] cur_addr,
   input  logic [31:0] blk_size,
   input  logic [31:0] start_addr,
   input  logic [31:0] end_addr,
   input  logic        any_emitted,
   output logic [31:0] next_addr,
   output logic        hit
);

   logic in_block;
   logic tail_hit;

   assign next_addr = cur_addr + blk_size;
   assign in_block  = (start_addr >= cur_addr) && (start_addr < next_addr);
   assign tail_hit  = any_emitted && (end_addr > cur_addr);
   assign hit       = in_block || tail_hit;

endmodule

### rtl/fesrm_walk.sv
// ----------------------------------------------------------------------------
// fesrm_walk
// walk sequencer: one erase block per cycle via the block unit unless stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fesrm_walk import fesrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        start_valid,
   output logic        start_ready,
   input  logic [31:0] start_addr,
   input  logic [30:0] byte_length,
   input  logic        push_ready,
   output logic        push_valid,
   output result_type  push_data
);

   walk_state_type      state_ff, state_in;
   logic [31:0]         addr_ff, addr_in;
   logic [31:0]         start_ff, start_in;
   logic [31:0]         end_ff, end_in;
   logic [RIDX_W-1:0]   ri_ff, ri_in;
   logic [15:0]         blk_ff, blk_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cnt_next;
   result_type          pend_ff, pend_in;
   logic                pend_vld_ff, pend_vld_in;

   logic [31:0]         info;
   logic [31:0]         blk_size;
   logic [31:0]         next_addr;
   logic                hit;
   logic                stall;
   logic                last_region;

   assign info        = cfg.region_info[ri_ff];
   assign blk_size    = 32'(info[31:16]) << SIZE_SHIFT;
   assign last_region = ({1'b0, ri_ff} == (cfg.region_count - 3'd1));

   fesrm_blk_unit u_blk (
      .cur_addr    (addr_ff),
      .blk_size    (blk_size),
      .start_addr  (start_ff),
      .end_addr    (end_ff),
      .any_emitted (cnt_ff != '0),
      .next_addr   (next_addr),
      .hit         (hit)
   );

   assign start_ready = (state_ff == ST_IDLE);
   assign stall       = hit && pend_vld_ff && !push_ready;
   assign cnt_next    = hit ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      ri_in       = ri_ff;
      blk_in      = blk_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      push_valid  = 1'b0;
      push_data   = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               start_in    = start_addr;
               end_in      = start_addr + {1'b0, byte_length};
               addr_in     = cfg.flash_base;
               ri_in       = '0;
               blk_in      = '0;
               cnt_in      = '0;
               pend_vld_in = 1'b0;
               if ((byte_length == '0) || (cfg.region_count == '0)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!stall) begin
               addr_in = next_addr;
               cnt_in  = cnt_next;
               if (hit) begin
                  push_valid            = pend_vld_ff;
                  push_data             = pend_ff;
                  push_data.last        = 1'b0;
                  pend_in.sector_addr   = addr_ff;
                  pend_in.valid_res     = 1'b1;
                  pend_in.last          = 1'b0;
                  pend_vld_in           = 1'b1;
               end
               if (cnt_next == CNT_W'(MAX_SECTORS)) begin
                  state_in = ST_FLUSH;
               end else if (blk_ff == info[15:0]) begin
                  if (last_region) begin
                     state_in = ST_FLUSH;
                  end else begin
                     ri_in  = ri_ff + RIDX_W'(1);
                     blk_in = '0;
                  end
               end else begin
                  blk_in = blk_ff + 16'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (push_ready) begin
               push_valid = 1'b1;
               if (pend_vld_ff) begin
                  push_data.sector_addr = pend_ff.sector_addr;
                  push_data.valid_res   = 1'b1;
               end else begin
                  push_data.sector_addr = '0;
                  push_data.valid_res   = 1'b0;
               end
               push_data.last = 1'b1;
               pend_vld_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in    = ST_IDLE;
            pend_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      ri_ff    <= ri_in;
      blk_ff   <= blk_in;
      pend_ff  <= pend_in;
   end

   `FESRM_ASSERT(a_push_has_room, clock, reset, push_valid |-> push_ready)
   `FESRM_NEVER(a_cnt_bound, clock, reset, cnt_ff > CNT_W'(MAX_SECTORS))
   `FESRM_ASSERT(a_idle_no_pend, clock, reset, (state_ff == ST_IDLE) |-> !pend_vld_ff)
   `FESRM_ASSERT(a_walk_pend, clock, reset, (state_ff == ST_WALK && cnt_ff != '0) |-> pend_vld_ff)
   `FESRM_ASSERT(a_flush_done, clock, reset, (state_ff == ST_FLUSH && push_ready) |=> (state_ff == ST_IDLE))

endmodule

### rtl/flash_erase_sector_range_mapper.sv
// ----------------------------------------------------------------------------
// flash_erase_sector_range_mapper
// maps an erase byte range onto the start addresses of cfi erase sectors
// ----------------------------------------------------------------------------
// usage
//   csr channel: writes flash base, region count and four region words;
//   always ready, write only while no request is in flight
//   req channel: one transaction per erase request (start, byte length)
//   rsp channel: one transaction per touched sector, tuser set when the
//   address is meaningful, tlast on the final one of the request; an empty
//   range or no hit gives a single transaction with tuser low
//   timing: one erase block examined per cycle by the block unit (one
//   32-bit add and three compares) unless a stall holds the walk; a found
//   sector is held until the next one is found or the walk ends, then is
//   registered and shows on rsp in the next cycle; the walk ends after the
//   last block of the last region or after 64 sectors
//   req_tready is high only while no walk runs
//   a stalled rsp side holds the walk when a second sector is found while
//   the output register is still full
//   reset: configuration and count zero, walk idle, output register empty
// ----------------------------------------------------------------------------
module flash_erase_sector_range_mapper import fesrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // start_addr[31:0], byte_length[62:32], zero[63]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sector_addr[31:0]
   output logic        rsp_tuser,   // valid_res[0]
   output logic        rsp_tlast
);

   cfg_type    cfg;
   logic       push_ready;
   logic       push_valid;
   result_type push_data;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;

   fesrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fesrm_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .start_valid (req_tvalid),
      .start_ready (req_tready),
      .start_addr  (req_tdata[31:0]),
      .byte_length (req_tdata[62:32]),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   assign push_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (push_valid) begin
         out_vld_in = 1'b1;
         out_in     = push_data;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.sector_addr;
   assign rsp_tuser  = out_ff.valid_res;
   assign rsp_tlast  = out_ff.last;

endmodule

### dv/flash_erase_sector_range_mapper_test.sv
// ----------------------------------------------------------------------------
// flash_erase_sector_range_mapper_test
// self-checking bench: erase requests go in on the req stream, and every
// returned transaction's address, tuser and tlast are checked against values
// from a shadow copy of the flash map; the map is reprogrammed between
// request batches, first with hand-picked layouts, then with random ones
// ----------------------------------------------------------------------------
module flash_erase_sector_range_mapper_test;
   import fesrm_pkg::*;

   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;
   localparam int RANDOM_BATCHES = 6;
   localparam int BATCH_REQUESTS = 17;

   typedef struct {
      logic [31:0] start_addr;
      logic [30:0] byte_length;
   } erase_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   erase_request_type erase_req_q[$];
   result_type        pending_sectors[$];

   logic [31:0] map_base = '0;
   logic [2:0]  map_regions = '0;
   logic [31:0] map_region_info [REGION_SLOTS] = '{default: '0};

   int  req_issued = 0;
   int  req_accepted = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  mismatch_count = 0;
   bit  idle_on = 1'b1;

   flash_erase_sector_range_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // start_addr[31:0], byte_length[62:32], zero[63]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sector_addr[31:0]
      .rsp_tuser  (rsp_tuser),   // valid_res[0]
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h, at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // walks the shadow map block by block and queues the sectors the range touches
   function automatic void predict_erase_sectors(input logic [31:0] start,
                                                 input logic [30:0] len);
      logic [31:0] range_end;
      logic [31:0] cur;
      logic [31:0] nxt;
      logic [31:0] size;
      logic [16:0] blocks;
      int          nreg;
      int          found;
      bit          have_prev;
      result_type  prev;
      result_type  hit;
      range_end = start + {1'b0, len};
      nreg = (map_regions > MAX_REGIONS) ? MAX_REGIONS : int'(map_regions);
      nxt = map_base;
      found = 0;
      have_prev = 1'b0;
      prev = '0;
      if (len != '0) begin
         for (int r = 0; r < nreg && found < MAX_SECTORS; r++) begin
            blocks = {1'b0, map_region_info[r][15:0]} + 17'd1;
            size = {8'h00, map_region_info[r][31:16], 8'h00};
            for (int b = 0; b < int'(blocks) && found < MAX_SECTORS; b++) begin
               cur = nxt;
               nxt = cur + size;
               if ((start >= cur && start < nxt) || (found > 0 && range_end > cur)) begin
                  if (have_prev) pending_sectors.push_back(prev);
                  hit.sector_addr = cur;
                  hit.valid_res = 1'b1;
                  hit.last = 1'b0;
                  prev = hit;
                  have_prev = 1'b1;
                  found++;
               end
            end
         end
      end
      if (found == 0) begin
         hit.sector_addr = '0;
         hit.valid_res = 1'b0;
         hit.last = 1'b1;
         pending_sectors.push_back(hit);
      end else begin
         prev.last = 1'b1;
         pending_sectors.push_back(prev);
      end
   endfunction

   function automatic longint mapped_span();
      longint total;
      int     nreg;
      total = 0;
      nreg = (map_regions > MAX_REGIONS) ? MAX_REGIONS : int'(map_regions);
      for (int r = 0; r < nreg; r++)
         total += longint'(map_region_info[r][31:16]) * 256 *
                  (longint'(map_region_info[r][15:0]) + 1);
      return total;
   endfunction

   function automatic bit mapper_busy();
      return erase_req_q.size() > 0 || req_issued != req_accepted ||
             pending_sectors.size() > 0;
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_FLASH_BASE:   map_base = data;
         REG_REGION_COUNT: map_regions = data[2:0];
         REG_REGION0:      map_region_info[0] = data;
         REG_REGION1:      map_region_info[1] = data;
         REG_REGION2:      map_region_info[2] = data;
         REG_REGION3:      map_region_info[3] = data;
         default: ;
      endcase
   endtask

   task automatic write_flash_map(input logic [31:0] base, input logic [2:0] regions,
                                  input logic [31:0] r0, input logic [31:0] r1,
                                  input logic [31:0] r2, input logic [31:0] r3);
      write_csr(REG_FLASH_BASE, base);
      write_csr(REG_REGION_COUNT, {29'h0, regions});
      write_csr(REG_REGION0, r0);
      write_csr(REG_REGION1, r1);
      write_csr(REG_REGION2, r2);
      write_csr(REG_REGION3, r3);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic queue_erase(input logic [31:0] start, input logic [30:0] len);
      erase_request_type req;
      req.start_addr = start;
      req.byte_length = len;
      erase_req_q.push_back(req);
   endtask

   task automatic drain_mapper();
      while (mapper_busy()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_region_word();
      logic [15:0] size_units;
      logic [15:0] count_field;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) size_units = '0;
      else if (pick == 1) size_units = 16'($urandom_range(0, 65535));
      else size_units = 16'($urandom_range(1, 32));
      if ($urandom_range(0, 4) == 0) count_field = 16'($urandom_range(0, 63));
      else count_field = 16'($urandom_range(0, 15));
      return {size_units, count_field};
   endfunction

   // mostly ranges inside the mapped area, some fully random noise
   task automatic queue_random_erases(input int n);
      longint      span;
      longint      offset;
      logic [31:0] start;
      logic [31:0] len_limit;
      logic [30:0] len;
      int          pick;
      span = mapped_span();
      len_limit = (span / 3 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(span / 3 + 1);
      for (int i = 0; i < n; i++) begin
         offset = longint'($urandom);
         if (span == 0 || $urandom_range(0, 99) < 12) start = $urandom;
         else start = map_base + 32'(offset % span);
         pick = $urandom_range(0, 9);
         if (pick == 0) len = 31'($urandom);
         else if (pick == 1) len = '0;
         else len = 31'($urandom_range(1, len_limit));
         queue_erase(start, len);
      end
   endtask

   always @(negedge clock) begin : req_driver
      erase_request_type req;
      if (!reset && req_issued == req_accepted) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (erase_req_q.size() > 0) begin
            req = erase_req_q.pop_front();
            req_tdata <= {1'b0, req.byte_length, req.start_addr};
            req_tvalid <= 1'b1;
            req_issued++;
            if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_pacer
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) rsp_stall = $urandom_range(1, 14);
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_erase_sectors(req_tdata[31:0], req_tdata[62:32]);
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_sectors.size() == 0) begin
               report_mismatch("unexpected sector transaction", rsp_tdata, '0);
            end else begin
               want = pending_sectors.pop_front();
               if (rsp_tdata !== want.sector_addr)
                  report_mismatch("sector_addr", rsp_tdata, want.sector_addr);
               if (rsp_tuser !== want.valid_res)
                  report_mismatch("valid_res", {31'h0, rsp_tuser}, {31'h0, want.valid_res});
               if (rsp_tlast !== want.last)
                  report_mismatch("last", {31'h0, rsp_tlast}, {31'h0, want.last});
            end
         end
      end
   end

   initial begin : watchdog
      #48000000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty map straight out of reset
      queue_erase(32'h0000_0000, 31'd1);
      queue_erase(32'hFFFF_FFFF, 31'h7FFF_FFFF);
      queue_erase(32'h1234_5678, 31'd0);
      drain_mapper();

      // two regions: 8 x 4 KiB then 4 x 64 KiB
      write_flash_map(32'h1000_0000, 3'd2, 32'h0010_0007, 32'h0100_0003,
                      32'hFFFF_FFFF, 32'h0000_0000);
      queue_erase(32'h1000_0000, 31'h1000);
      queue_erase(32'h1000_0000, 31'd1);
      queue_erase(32'h1000_3800, 31'h9000);
      queue_erase(32'h0FFF_FFFF, 31'd2);
      queue_erase(32'h1004_8000, 31'd4);
      queue_erase(32'h1004_7FFF, 31'h7FFF_FFFF);
      queue_erase(32'h1000_3000, 31'h7FFF_FFFF);
      queue_erase(32'h1000_0010, 31'd0);
      drain_mapper();

      // map wrapping past zero, zero-size blocks, clamped region count, spare indexes
      write_csr(REG_SPARE6, $urandom);
      write_csr(REG_SPARE7, $urandom);
      write_flash_map(32'hFFFF_FE00, 3'd7, 32'h0001_0003, 32'h0000_0002,
                      32'h0002_0001, 32'h0000_0000);
      queue_erase(32'hFFFF_FE80, 31'h100);
      queue_erase(32'hFFFF_FF00, 31'h400);
      queue_erase(32'h0000_0050, 31'h7FFF_FFFF);
      queue_erase(32'h0000_0600, 31'd1);
      queue_erase(32'h0000_0000, 31'h10);
      drain_mapper();

      // more sectors than one request may emit
      write_flash_map(32'h0000_0000, 3'd1, 32'h0001_0063, 32'h0003_0001,
                      32'h0000_0005, 32'hFFFF_0000);
      queue_erase(32'h0000_0000, 31'h7FFF_FFFF);
      queue_erase(32'h0000_5000, 31'h1000);
      drain_mapper();

      // full block count field
      write_flash_map(32'h8000_0000, 3'd1, 32'h0001_FFFF, 32'h0001_0001,
                      32'h0001_0001, 32'h0001_0001);
      queue_erase(32'h8000_0000, 31'h7FFF_FFFF);
      queue_erase(32'h80FF_FF80, 31'h10);
      queue_erase(32'h0000_0010, 31'd1);
      drain_mapper();

      for (int p = 0; p < RANDOM_BATCHES; p++) begin
         if (p == RANDOM_BATCHES - 1) idle_on = 1'b0;
         write_flash_map($urandom,
                         ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                     : 3'($urandom_range(1, 4)),
                         random_region_word(), random_region_word(),
                         random_region_word(), random_region_word());
         queue_random_erases(BATCH_REQUESTS);
         drain_mapper();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/fesrm_pkg.sv
rtl/fesrm_csr.sv
rtl/fesrm_blk_unit.sv
rtl/fesrm_walk.sv
rtl/flash_erase_sector_range_mapper.sv
dv/flash_erase_sector_range_mapper_test.sv
